// ----- rtl/tlam_pkg.sv -----
// shared types, constants and functions for the two-lap accumulate map orbit stepper
// holds the elaboration-time matrix build; no dependencies
package tlam_pkg;

    localparam int unsigned STATE_W    = 64;
    localparam int unsigned WEIGHT_W   = 22;
    localparam int unsigned NODE_W     = 16;
    localparam int unsigned NIBBLE_W   = 4;
    localparam int unsigned NIBBLES    = STATE_W / NIBBLE_W;
    localparam int unsigned TARGET_W   = 2;
    localparam int unsigned POP_W      = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = WEIGHT_W;

    localparam logic [STATE_W-1:0] GEN_POLY    = 64'hF4845518B9582A1F;
    localparam logic [NODE_W-1:0]  ORBIT_NODES = 16'd32772;
    localparam logic [NODE_W-1:0]  ORBIT_LAST  = ORBIT_NODES - 16'd1;
    localparam logic [NODE_W-1:0]  NODE_MAX    = '1;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_VALUE  = 2'd0,
        CFG_SECOND_VALUE = 2'd1,
        CFG_TARGET_FIRST = 2'd2,
        CFG_WEIGHT_THR   = 2'd3
    } t_cfg_idx;

    localparam logic [NIBBLE_W-1:0] FIRST_VALUE_RST  = 4'd10;
    localparam logic [NIBBLE_W-1:0] SECOND_VALUE_RST = 4'd13;
    localparam logic [TARGET_W-1:0] TARGET_FIRST_RST = 2'd3;
    localparam logic [WEIGHT_W-1:0] WEIGHT_THR_RST   = 22'd188766;
    localparam logic [TARGET_W-1:0] TARGET_TOTAL     = 2'd3;

    typedef struct packed {
        logic [NIBBLE_W-1:0] first_value;
        logic [NIBBLE_W-1:0] second_value;
        logic [TARGET_W-1:0] target_first_count;
        logic [WEIGHT_W-1:0] weight_threshold;
    } t_cfg;

    // one lap step result for both laps
    typedef struct packed {
        logic [STATE_W-1:0] first_state;
        logic [STATE_W-1:0] second_state;
        logic [POP_W-1:0]   first_pop;
        logic [POP_W-1:0]   second_pop;
    } t_lap_res;

    // matrix stored as rows: row j holds bit j of every column
    typedef logic [STATE_W-1:0][STATE_W-1:0] t_mat;

    function automatic logic [STATE_W-1:0] clmul_lo(
        input logic [STATE_W-1:0] a,
        input logic [STATE_W-1:0] b
    );
        logic [STATE_W-1:0] r;
        r = '0;
        for (int i = 0; i < STATE_W; i++) begin
            if (b[i]) begin
                r = r ^ (a << i);
            end
        end
        return r;
    endfunction

    // high word of the systematic encoding of a message
    function automatic logic [STATE_W-1:0] high_word(input logic [STATE_W-1:0] msg);
        logic [STATE_W-1:0] h;
        logic [STATE_W-1:0] part;
        h = '0;
        for (int i = 0; i < STATE_W; i++) begin
            if (msg[i]) begin
                part = (i == 0) ? '0 : (GEN_POLY >> (STATE_W - i));
                h = h ^ (part | {1'b1, {(STATE_W-1){1'b0}}});
            end
        end
        return h;
    endfunction

    function automatic t_mat build_rows();
        logic [STATE_W-1:0] inv;
        logic [STATE_W-1:0] col;
        logic [STATE_W-1:0] prod;
        t_mat rows;
        inv = {{(STATE_W-1){1'b0}}, 1'b1};
        rows = '0;
        // inverse of the generator modulo x^64
        for (int i = 1; i < STATE_W; i++) begin
            prod = clmul_lo(GEN_POLY, inv);
            if (prod[i]) begin
                inv[i] = 1'b1;
            end
        end
        for (int c = 0; c < STATE_W; c++) begin
            col = high_word(clmul_lo({{(STATE_W-1){1'b0}}, 1'b1} << c, inv));
            for (int j = 0; j < STATE_W; j++) begin
                rows[j][c] = col[j];
            end
        end
        return rows;
    endfunction

    localparam t_mat MAT_ROWS = build_rows();

    function automatic logic [STATE_W-1:0] prefix_xor(input logic [STATE_W-1:0] v);
        logic [STATE_W-1:0] r;
        r = v;
        r = r ^ (r << 1);
        r = r ^ (r << 2);
        r = r ^ (r << 4);
        r = r ^ (r << 8);
        r = r ^ (r << 16);
        r = r ^ (r << 32);
        return r;
    endfunction

    function automatic logic [STATE_W-1:0] mat_apply(input logic [STATE_W-1:0] v);
        logic [STATE_W-1:0] r;
        for (int j = 0; j < STATE_W; j++) begin
            r[j] = ^(v & MAT_ROWS[j]);
        end
        return r;
    endfunction

    // adder tree, six levels
    function automatic logic [POP_W-1:0] popcount64(input logic [STATE_W-1:0] v);
        logic [POP_W-1:0] s [STATE_W];
        for (int k = 0; k < STATE_W; k++) begin
            s[k] = {{(POP_W-1){1'b0}}, v[k]};
        end
        for (int w = 1; w < STATE_W; w = w * 2) begin
            for (int k = 0; k < STATE_W; k = k + 2 * w) begin
                s[k] = s[k] + s[k + w];
            end
        end
        return s[0];
    endfunction

    // adder tree, four levels
    function automatic logic [4:0] popcount16(input logic [NIBBLES-1:0] v);
        logic [4:0] s [NIBBLES];
        for (int k = 0; k < NIBBLES; k++) begin
            s[k] = {4'b0, v[k]};
        end
        for (int w = 1; w < NIBBLES; w = w * 2) begin
            for (int k = 0; k < NIBBLES; k = k + 2 * w) begin
                s[k] = s[k] + s[k + w];
            end
        end
        return s[0];
    endfunction

endpackage

// ----- rtl/tlam_if.sv -----
// valid/ready channel interfaces for requests and results
// depends on tlam_pkg
interface tlam_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [tlam_pkg::STATE_W-1:0]  initial_drive;

    modport source (output valid, output req_type, output initial_drive, input ready);
    modport sink   (input valid, input req_type, input initial_drive, output ready);
endinterface

interface tlam_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          first_turnoff;
    logic                          double_turnoff;
    logic                          below_threshold;
    logic [tlam_pkg::NODE_W-1:0]   node_index;
    logic                          orbit_end;
    logic [tlam_pkg::WEIGHT_W-1:0] first_weight;
    logic [tlam_pkg::WEIGHT_W-1:0] second_weight;
    logic [tlam_pkg::STATE_W-1:0]  first_state_out;

    modport source (
        output valid, output first_turnoff, output double_turnoff, output below_threshold,
        output node_index, output orbit_end, output first_weight, output second_weight,
        output first_state_out, input ready
    );
    modport sink (
        input valid, input first_turnoff, input double_turnoff, input below_threshold,
        input node_index, input orbit_end, input first_weight, input second_weight,
        input first_state_out, output ready
    );
endinterface

// ----- rtl/tlam_lap.sv -----
// one orbit step of both laps: prefix-xor accumulate, constant matrix, popcounts
// depends on tlam_pkg
module tlam_lap (
    input  logic [tlam_pkg::STATE_W-1:0] i_first_state,
    input  logic [tlam_pkg::STATE_W-1:0] i_second_state,
    output tlam_pkg::t_lap_res           o_res
);

    logic [tlam_pkg::STATE_W-1:0] acc_first;
    logic [tlam_pkg::STATE_W-1:0] acc_second;

    // second lap is driven by the first lap's accumulate
    assign acc_first  = tlam_pkg::prefix_xor(i_first_state);
    assign acc_second = tlam_pkg::prefix_xor(i_second_state ^ acc_first);

    assign o_res.first_state  = tlam_pkg::mat_apply(acc_first);
    assign o_res.second_state = tlam_pkg::mat_apply(acc_second);
    assign o_res.first_pop    = tlam_pkg::popcount64(acc_first);
    assign o_res.second_pop   = tlam_pkg::popcount64(acc_second);

endmodule

// ----- rtl/tlam_match.sv -----
// nibble value count check on the first lap state
// depends on tlam_pkg
module tlam_match (
    input  logic [tlam_pkg::STATE_W-1:0] i_state,
    input  tlam_pkg::t_cfg               i_cfg,
    output logic                         o_match
);

    logic [tlam_pkg::NIBBLES-1:0] eq_first;
    logic [tlam_pkg::NIBBLES-1:0] eq_second;
    logic [tlam_pkg::NIBBLES-1:0] stray;
    logic [4:0]                   cnt_first;
    logic [4:0]                   cnt_second;
    logic [tlam_pkg::TARGET_W-1:0] target_second;

    always_comb begin
        for (int k = 0; k < tlam_pkg::NIBBLES; k++) begin
            eq_first[k]  = i_state[k*tlam_pkg::NIBBLE_W +: tlam_pkg::NIBBLE_W]
                           == i_cfg.first_value;
            eq_second[k] = i_state[k*tlam_pkg::NIBBLE_W +: tlam_pkg::NIBBLE_W]
                           == i_cfg.second_value;
            // nonzero nibble that is neither value
            stray[k]     = (|i_state[k*tlam_pkg::NIBBLE_W +: tlam_pkg::NIBBLE_W])
                           && !eq_first[k] && !eq_second[k];
        end
    end

    assign cnt_first     = tlam_pkg::popcount16(eq_first);
    assign cnt_second    = tlam_pkg::popcount16(eq_second);
    assign target_second = tlam_pkg::TARGET_TOTAL - i_cfg.target_first_count;

    assign o_match = !(|stray)
                     && (cnt_first  == {3'b0, i_cfg.target_first_count})
                     && (cnt_second == {3'b0, target_second});

endmodule

// ----- rtl/two_lap_accumulate_map_orbit.sv -----
// latency: a result is valid in the cycle after its request transaction
// throughput: one request per cycle while results are drained; both laps, matrix and popcounts are combinational
// a request is taken while the result register is empty or being drained the same cycle
// reset (synchronous, active low) clears the states, weights, node counter and result valid,
// and loads the registers with their defaults
// depends on tlam_pkg, tlam_if, tlam_lap, tlam_match
module two_lap_accumulate_map_orbit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tlam_req_if.sink                        i_req,
    tlam_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [tlam_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tlam_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    tlam_pkg::t_cfg r_cfg;

    // orbit state
    logic [tlam_pkg::STATE_W-1:0]  r_first_state;
    logic [tlam_pkg::STATE_W-1:0]  r_second_state;
    logic [tlam_pkg::WEIGHT_W-1:0] r_first_weight;
    logic [tlam_pkg::WEIGHT_W-1:0] r_second_weight;
    logic [tlam_pkg::NODE_W-1:0]   r_node;

    // result register
    logic                          r_out_valid;
    logic                          r_first_turnoff;
    logic                          r_double_turnoff;
    logic                          r_below_threshold;
    logic                          r_orbit_end;

    // next values
    logic [tlam_pkg::STATE_W-1:0]  n_first_state;
    logic [tlam_pkg::STATE_W-1:0]  n_second_state;
    logic [tlam_pkg::WEIGHT_W-1:0] n_first_weight;
    logic [tlam_pkg::WEIGHT_W-1:0] n_second_weight;
    logic [tlam_pkg::NODE_W-1:0]   n_node;
    logic                          n_first_turnoff;
    logic                          n_double_turnoff;
    logic                          n_below_threshold;
    logic                          n_orbit_end;

    tlam_pkg::t_lap_res            lap;
    logic                          step_match;
    logic [tlam_pkg::WEIGHT_W:0]   sum_first;
    logic [tlam_pkg::WEIGHT_W:0]   sum_second;
    logic [tlam_pkg::WEIGHT_W-1:0] step_first_weight;
    logic [tlam_pkg::WEIGHT_W-1:0] step_second_weight;
    logic [tlam_pkg::NODE_W-1:0]   step_node;
    logic                          in_fire;

    // output register drains or is empty: room for the next transaction
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign in_fire     = i_req.valid && i_req.ready;

    // one orbit step from the current state
    tlam_lap u_lap (
        .i_first_state  (r_first_state),
        .i_second_state (r_second_state),
        .o_res          (lap)
    );

    // count check on the freshly stepped first state
    tlam_match u_match (
        .i_state (lap.first_state),
        .i_cfg   (r_cfg),
        .o_match (step_match)
    );

    // saturating weight adds: the maximum is all ones, so a carry out saturates
    assign sum_first  = {1'b0, r_first_weight}
                        + {{(tlam_pkg::WEIGHT_W+1-tlam_pkg::POP_W){1'b0}}, lap.first_pop};
    assign sum_second = {1'b0, r_second_weight}
                        + {{(tlam_pkg::WEIGHT_W+1-tlam_pkg::POP_W){1'b0}}, lap.second_pop};
    assign step_first_weight  = sum_first[tlam_pkg::WEIGHT_W]  ? '1
                                : sum_first[tlam_pkg::WEIGHT_W-1:0];
    assign step_second_weight = sum_second[tlam_pkg::WEIGHT_W] ? '1
                                : sum_second[tlam_pkg::WEIGHT_W-1:0];

    // node counter stops at its maximum
    assign step_node = (r_node == tlam_pkg::NODE_MAX) ? r_node : r_node + 16'd1;

    always_comb begin
        if (i_req.req_type == tlam_pkg::REQ_STEP) begin
            n_first_state     = lap.first_state;
            n_second_state    = lap.second_state;
            n_first_weight    = step_first_weight;
            n_second_weight   = step_second_weight;
            n_node            = step_node;
            n_first_turnoff   = step_match;
            n_double_turnoff  = step_match && (lap.second_state == '0);
            n_below_threshold = n_double_turnoff
                                && (step_second_weight < r_cfg.weight_threshold);
            n_orbit_end       = step_node >= tlam_pkg::ORBIT_LAST;
        end else begin
            // load: fresh drive, second lap and counters cleared
            n_first_state     = i_req.initial_drive;
            n_second_state    = '0;
            n_first_weight    = '0;
            n_second_weight   = '0;
            n_node            = '0;
            n_first_turnoff   = 1'b0;
            n_double_turnoff  = 1'b0;
            n_below_threshold = 1'b0;
            n_orbit_end       = 1'b0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_value        <= tlam_pkg::FIRST_VALUE_RST;
            r_cfg.second_value       <= tlam_pkg::SECOND_VALUE_RST;
            r_cfg.target_first_count <= tlam_pkg::TARGET_FIRST_RST;
            r_cfg.weight_threshold   <= tlam_pkg::WEIGHT_THR_RST;
        end else if (i_cfg_we) begin
            unique case (tlam_pkg::t_cfg_idx'(i_cfg_idx))
                tlam_pkg::CFG_FIRST_VALUE: begin
                    r_cfg.first_value <= i_cfg_data[tlam_pkg::NIBBLE_W-1:0];
                end
                tlam_pkg::CFG_SECOND_VALUE: begin
                    r_cfg.second_value <= i_cfg_data[tlam_pkg::NIBBLE_W-1:0];
                end
                tlam_pkg::CFG_TARGET_FIRST: begin
                    r_cfg.target_first_count <= i_cfg_data[tlam_pkg::TARGET_W-1:0];
                end
                tlam_pkg::CFG_WEIGHT_THR: begin
                    r_cfg.weight_threshold <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // orbit state is stepped or loaded on every request transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_state   <= '0;
            r_second_state  <= '0;
            r_first_weight  <= '0;
            r_second_weight <= '0;
            r_node          <= '0;
        end else if (in_fire) begin
            r_first_state   <= n_first_state;
            r_second_state  <= n_second_state;
            r_first_weight  <= n_first_weight;
            r_second_weight <= n_second_weight;
            r_node          <= n_node;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result flags; the weights, node and state come from the state registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_first_turnoff   <= n_first_turnoff;
            r_double_turnoff  <= n_double_turnoff;
            r_below_threshold <= n_below_threshold;
            r_orbit_end       <= n_orbit_end;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.first_turnoff   = r_first_turnoff;
    assign o_rsp.double_turnoff  = r_double_turnoff;
    assign o_rsp.below_threshold = r_below_threshold;
    assign o_rsp.node_index      = r_node;
    assign o_rsp.orbit_end       = r_orbit_end;
    assign o_rsp.first_weight    = r_first_weight;
    assign o_rsp.second_weight   = r_second_weight;
    assign o_rsp.first_state_out = r_first_state;

endmodule

// ----- rtl/tlam_checker.sv -----
// port-level checks for the orbit stepper, attached to the top level by bind
// depends on tlam_pkg and two_lap_accumulate_map_orbit
module tlam_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic                          i_req_type,
    input  logic [tlam_pkg::STATE_W-1:0]  i_drive,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_ready,
    input  logic                          i_first_turnoff,
    input  logic                          i_double_turnoff,
    input  logic                          i_below_threshold,
    input  logic [tlam_pkg::NODE_W-1:0]   i_node_index,
    input  logic                          i_orbit_end,
    input  logic [tlam_pkg::WEIGHT_W-1:0] i_first_weight,
    input  logic [tlam_pkg::WEIGHT_W-1:0] i_second_weight,
    input  logic [tlam_pkg::STATE_W-1:0]  i_first_state_out
);

    // stalled result keeps its transaction
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid
        && $stable({i_first_turnoff, i_double_turnoff, i_below_threshold, i_node_index,
                    i_orbit_end, i_first_weight, i_second_weight, i_first_state_out}))
        else $error("result changed while stalled");

    // a load returns the drive with cleared counters in the next cycle
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_type == tlam_pkg::REQ_LOAD) |=>
        i_rsp_valid && (i_node_index == '0) && (i_first_weight == '0)
        && (i_second_weight == '0) && !i_first_turnoff && (i_first_state_out == $past(i_drive)))
        else $error("load result wrong");

    // flag chain
    a_flag_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (!i_below_threshold || i_double_turnoff)
        && (!i_double_turnoff || i_first_turnoff))
        else $error("turnoff flags inconsistent");

    // end of orbit follows the node index
    a_orbit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_orbit_end == (i_node_index >= tlam_pkg::ORBIT_LAST)))
        else $error("orbit end mismatch");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

endmodule

bind two_lap_accumulate_map_orbit tlam_checker u_tlam_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_req_type        (i_req.req_type),
    .i_drive           (i_req.initial_drive),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_first_turnoff   (o_rsp.first_turnoff),
    .i_double_turnoff  (o_rsp.double_turnoff),
    .i_below_threshold (o_rsp.below_threshold),
    .i_node_index      (o_rsp.node_index),
    .i_orbit_end       (o_rsp.orbit_end),
    .i_first_weight    (o_rsp.first_weight),
    .i_second_weight   (o_rsp.second_weight),
    .i_first_state_out (o_rsp.first_state_out)
);
